// ===== sv/text_cursor_glyph_placer_defines.svh =====
// Assertion macros for the text cursor glyph placer.
// Macros expect a clock aclk and an active low reset aresetn in scope.
`ifndef TEXT_CURSOR_GLYPH_PLACER_DEFINES_SVH
`define TEXT_CURSOR_GLYPH_PLACER_DEFINES_SVH

// Same-cycle implication.
`define TCGP_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("tcgp: same-cycle check failed");

// Next-cycle implication.
`define TCGP_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("tcgp: next-cycle check failed");

`endif

// ===== sv/tcgp_pkg.sv =====
// Shared types, constants and helper functions for the text cursor glyph placer.
// No dependencies.
`default_nettype none

package tcgp_pkg;

    localparam int CUR_W   = 12;
    localparam int FONT_W  = 7;
    localparam int CODE_W  = 8;
    localparam int OFF_W   = 17;
    localparam int GW_W    = 7;
    localparam int BPF_W   = 12;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;

    localparam int TAB_SPACES = 4;
    localparam int TAB_CNT_W  = (TAB_SPACES > 1) ? $clog2(TAB_SPACES) : 1;

    localparam logic [CODE_W-1:0] CODE_TAB   = 8'd9;
    localparam logic [CODE_W-1:0] CODE_LF    = 8'd10;
    localparam logic [CODE_W-1:0] CODE_CR    = 8'd13;
    localparam logic [CODE_W-1:0] CODE_SPACE = 8'd32;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_DISP_W  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DISP_H  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FONT_W  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FONT_H  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WIDE    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FIRST   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_LAST    = 3'd6;

    localparam logic [CUR_W-1:0]  RST_DISP_W = 12'd240;
    localparam logic [CUR_W-1:0]  RST_DISP_H = 12'd240;
    localparam logic [FONT_W-1:0] RST_FONT_W = 7'd8;
    localparam logic [FONT_W-1:0] RST_FONT_H = 7'd8;
    localparam logic [CODE_W-1:0] RST_FIRST  = 8'd32;
    localparam logic [CODE_W-1:0] RST_LAST   = 8'd126;

    // Kind of the word being worked on.
    localparam logic [1:0] KIND_DRAW = 2'd0;
    localparam logic [1:0] KIND_CR   = 2'd1;
    localparam logic [1:0] KIND_LF   = 2'd2;
    localparam logic [1:0] KIND_TAB  = 2'd3;

    typedef struct packed {
        logic [CUR_W-1:0] a;
        logic [CUR_W-1:0] b;
        logic [CUR_W-1:0] bound;
    } alu_req_t;

    typedef struct packed {
        logic [CUR_W-1:0] sum_sat;
        logic             ge;
    } alu_rsp_t;

    // ceil(fw / 3) as (fw + 2) * 171 >> 9, exact for fw below 128; doubled in wide mode.
    function automatic logic [GW_W-1:0] glyph_width(input logic [FONT_W-1:0] fw,
                                                    input logic wide);
        logic [7:0]  s;
        logic [15:0] p;
        logic [5:0]  w;
        s = {1'b0, fw} + 8'd2;
        p = 16'(s) * 16'd171;
        w = p[14:9];
        return wide ? {w, 1'b0} : {1'b0, w};
    endfunction

    // Bytes per glyph row: ceil(fw / 8).
    function automatic logic [4:0] row_bytes(input logic [FONT_W-1:0] fw);
        logic [7:0] s;
        s = {1'b0, fw} + 8'd7;
        return s[7:3];
    endfunction

endpackage

`default_nettype wire

// ===== sv/tcgp_alu.sv =====
// Shared add / saturate / compare unit of the text cursor glyph placer.
// Depends on tcgp_pkg.
`default_nettype none

module tcgp_alu (
    input  tcgp_pkg::alu_req_t req,
    output tcgp_pkg::alu_rsp_t rsp
);

    logic [tcgp_pkg::CUR_W:0] sum;

    always_comb begin
        sum = {1'b0, req.a} + {1'b0, req.b};
        // clamp at full scale
        rsp.sum_sat = sum[tcgp_pkg::CUR_W] ? {tcgp_pkg::CUR_W{1'b1}}
                                            : sum[tcgp_pkg::CUR_W-1:0];
        rsp.ge      = (sum >= {1'b0, req.bound});
    end

endmodule

`default_nettype wire

// ===== sv/text_cursor_glyph_placer.sv =====
// Top level of the text cursor glyph placer: sequencer, cursor state, output register.
// Depends on tcgp_pkg, tcgp_alu and text_cursor_glyph_placer_defines.svh.
//
//   channel  prefix  dir  handshake            payload
//   input    s_      in   s_valid / s_ready    s_char_code
//   result   m_      out  m_valid / m_ready    window, glyph_offset, flags
//   config   cfg_    in   cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One word at a time: s_ready is high only while the sequencer is idle. Every
// cursor add and compare goes through one shared adder, one operation per cycle,
// and an emit stalls while the output register is full.
// aresetn (synchronous) restores the register defaults and homes the cursor.
// The output register lets the next word be accepted while a result waits.
`default_nettype none
`include "text_cursor_glyph_placer_defines.svh"

module text_cursor_glyph_placer (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,

    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic [tcgp_pkg::CODE_W-1:0]       s_char_code,

    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic [tcgp_pkg::CUR_W-1:0]             m_win_x,
    output logic [tcgp_pkg::CUR_W-1:0]             m_win_y,
    output logic [tcgp_pkg::CUR_W-1:0]             m_win_x_end,
    output logic [tcgp_pkg::CUR_W-1:0]             m_win_y_end,
    output logic [tcgp_pkg::OFF_W-1:0]             m_glyph_offset,
    output logic                                   m_reload_glyph,
    output logic                                   m_last_of_run,

    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [tcgp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [tcgp_pkg::CFG_DATA_W-1:0]   cfg_data
);

    // Sequencer states.
    localparam logic [3:0] ST_IDLE = 4'd0;   // wait for a word
    localparam logic [3:0] ST_PREP = 4'd1;   // glyph width, bytes per glyph, glyph index
    localparam logic [3:0] ST_OFF  = 4'd2;   // glyph offset multiply
    localparam logic [3:0] ST_WX   = 4'd3;   // wrap test: x + gw >= width
    localparam logic [3:0] ST_WY   = 4'd4;   // wrap: y += fh, x = 0
    localparam logic [3:0] ST_WH   = 4'd5;   // origin test: y >= height
    localparam logic [3:0] ST_ACT  = 4'd6;   // dispatch on word kind
    localparam logic [3:0] ST_LFY  = 4'd7;   // line feed: y += fh, x = 0
    localparam logic [3:0] ST_DX   = 4'd8;   // window right bound
    localparam logic [3:0] ST_DY   = 4'd9;   // window bottom bound
    localparam logic [3:0] ST_EMIT = 4'd10;  // load the output register

    localparam int CW = tcgp_pkg::CUR_W;

    // Configuration registers.
    logic [CW-1:0]                   disp_w_reg, disp_w_next;
    logic [CW-1:0]                   disp_h_reg, disp_h_next;
    logic [tcgp_pkg::FONT_W-1:0]     font_w_reg, font_w_next;
    logic [tcgp_pkg::FONT_W-1:0]     font_h_reg, font_h_next;
    logic                            wide_reg, wide_next;
    logic [tcgp_pkg::CODE_W-1:0]     first_reg, first_next;
    logic [tcgp_pkg::CODE_W-1:0]     last_reg, last_next;

    // Sequencer and cursor state.
    logic [3:0]                      state_reg, state_next;
    logic [1:0]                      kind_reg, kind_next;
    logic                            in_loop_reg, in_loop_next;
    logic [tcgp_pkg::TAB_CNT_W-1:0]  tab_cnt_reg, tab_cnt_next;
    logic [tcgp_pkg::CODE_W-1:0]     code_reg, code_next;
    logic [CW-1:0]                   cur_x_reg, cur_x_next;
    logic [CW-1:0]                   cur_y_reg, cur_y_next;
    logic [tcgp_pkg::CODE_W-1:0]     drawn_reg, drawn_next;

    // Per-word working values.
    logic [tcgp_pkg::GW_W-1:0]       gw_reg, gw_next;
    logic [tcgp_pkg::BPF_W-1:0]      bpf_reg, bpf_next;
    logic [tcgp_pkg::CODE_W-1:0]     idx_reg, idx_next;
    logic [tcgp_pkg::OFF_W-1:0]      off_reg, off_next;
    logic [CW-1:0]                   xend_reg, xend_next;
    logic [CW-1:0]                   yend_reg, yend_next;

    // Output register.
    logic                            m_valid_reg, m_valid_next;
    logic [CW-1:0]                   out_x_reg, out_x_next;
    logic [CW-1:0]                   out_y_reg, out_y_next;
    logic [CW-1:0]                   out_xe_reg, out_xe_next;
    logic [CW-1:0]                   out_ye_reg, out_ye_next;
    logic [tcgp_pkg::OFF_W-1:0]      out_off_reg, out_off_next;
    logic                            out_rel_reg, out_rel_next;
    logic                            out_last_reg, out_last_next;

    tcgp_pkg::alu_req_t              alu_req;
    tcgp_pkg::alu_rsp_t              alu_rsp;

    logic                            out_free;
    logic                            load_out;
    logic                            last_draw;
    logic [tcgp_pkg::CODE_W+tcgp_pkg::BPF_W-1:0] off_full;

    tcgp_alu u_alu (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign out_free  = !m_valid_reg || m_ready;
    assign load_out  = (state_reg == ST_EMIT) && out_free;
    assign last_draw = (kind_reg != tcgp_pkg::KIND_TAB) ||
                       (tab_cnt_reg == tcgp_pkg::TAB_CNT_W'(tcgp_pkg::TAB_SPACES - 1));
    assign off_full  = (tcgp_pkg::CODE_W + tcgp_pkg::BPF_W)'(idx_reg) *
                       (tcgp_pkg::CODE_W + tcgp_pkg::BPF_W)'(bpf_reg);

    // Steer the shared adder by state.
    always_comb begin
        alu_req.a     = cur_x_reg;
        alu_req.b     = '0;
        alu_req.bound = disp_w_reg;
        unique case (state_reg)
            ST_WX, ST_DX: begin
                alu_req.a = cur_x_reg;
                alu_req.b = CW'(gw_reg);
            end
            ST_WY, ST_LFY, ST_DY: begin
                alu_req.a = cur_y_reg;
                alu_req.b = CW'(font_h_reg);
            end
            ST_WH: begin
                alu_req.a     = cur_y_reg;
                alu_req.bound = disp_h_reg;
            end
            default: begin
                alu_req.a = cur_x_reg;
            end
        endcase
    end

    always_comb begin
        disp_w_next  = disp_w_reg;
        disp_h_next  = disp_h_reg;
        font_w_next  = font_w_reg;
        font_h_next  = font_h_reg;
        wide_next    = wide_reg;
        first_next   = first_reg;
        last_next    = last_reg;

        state_next   = state_reg;
        kind_next    = kind_reg;
        in_loop_next = in_loop_reg;
        tab_cnt_next = tab_cnt_reg;
        code_next    = code_reg;
        cur_x_next   = cur_x_reg;
        cur_y_next   = cur_y_reg;
        drawn_next   = drawn_reg;
        gw_next      = gw_reg;
        bpf_next     = bpf_reg;
        idx_next     = idx_reg;
        off_next     = off_reg;
        xend_next    = xend_reg;
        yend_next    = yend_reg;

        m_valid_next  = m_valid_reg && !m_ready;
        out_x_next    = out_x_reg;
        out_y_next    = out_y_reg;
        out_xe_next   = out_xe_reg;
        out_ye_next   = out_ye_reg;
        out_off_next  = out_off_reg;
        out_rel_next  = out_rel_reg;
        out_last_next = out_last_reg;

        // Register writes; an index past the list is dropped.
        if (cfg_valid) begin
            unique case (cfg_index)
                tcgp_pkg::REG_DISP_W: disp_w_next = cfg_data;
                tcgp_pkg::REG_DISP_H: disp_h_next = cfg_data;
                tcgp_pkg::REG_FONT_W: font_w_next = cfg_data[tcgp_pkg::FONT_W-1:0];
                tcgp_pkg::REG_FONT_H: font_h_next = cfg_data[tcgp_pkg::FONT_W-1:0];
                tcgp_pkg::REG_WIDE:   wide_next   = cfg_data[0];
                tcgp_pkg::REG_FIRST:  first_next  = cfg_data[tcgp_pkg::CODE_W-1:0];
                tcgp_pkg::REG_LAST:   last_next   = cfg_data[tcgp_pkg::CODE_W-1:0];
                default: ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    in_loop_next = 1'b0;
                    tab_cnt_next = '0;
                    priority if (s_char_code == tcgp_pkg::CODE_CR) begin
                        kind_next = tcgp_pkg::KIND_CR;
                        code_next = s_char_code;
                    end else if (s_char_code == tcgp_pkg::CODE_LF) begin
                        kind_next = tcgp_pkg::KIND_LF;
                        code_next = s_char_code;
                    end else if (s_char_code == tcgp_pkg::CODE_TAB) begin
                        // a tab draws spaces
                        kind_next = tcgp_pkg::KIND_TAB;
                        code_next = tcgp_pkg::CODE_SPACE;
                    end else begin
                        kind_next = tcgp_pkg::KIND_DRAW;
                        code_next = s_char_code;
                    end
                    state_next = ST_PREP;
                end
            end
            ST_PREP: begin
                gw_next  = tcgp_pkg::glyph_width(font_w_reg, wide_reg);
                bpf_next = tcgp_pkg::BPF_W'(tcgp_pkg::row_bytes(font_w_reg)) *
                           tcgp_pkg::BPF_W'(font_h_reg);
                // out-of-font codes use glyph 0
                if ((code_reg >= first_reg) && (code_reg <= last_reg)) begin
                    idx_next = code_reg - first_reg;
                end else begin
                    idx_next = '0;
                end
                state_next = ST_OFF;
            end
            ST_OFF: begin
                if (off_full > (tcgp_pkg::CODE_W + tcgp_pkg::BPF_W)'({tcgp_pkg::OFF_W{1'b1}})) begin
                    off_next = {tcgp_pkg::OFF_W{1'b1}};
                end else begin
                    off_next = off_full[tcgp_pkg::OFF_W-1:0];
                end
                state_next = ST_WX;
            end
            ST_WX: begin
                state_next = alu_rsp.ge ? ST_WY : ST_WH;
            end
            ST_WY: begin
                cur_y_next = alu_rsp.sum_sat;
                cur_x_next = '0;
                state_next = ST_WH;
            end
            ST_WH: begin
                if (alu_rsp.ge) begin
                    cur_x_next = '0;
                    cur_y_next = '0;
                end
                state_next = in_loop_reg ? ST_DX : ST_ACT;
            end
            ST_ACT: begin
                unique case (kind_reg)
                    tcgp_pkg::KIND_CR: begin
                        cur_x_next = '0;
                        state_next = ST_IDLE;
                    end
                    tcgp_pkg::KIND_LF: begin
                        state_next = ST_LFY;
                    end
                    tcgp_pkg::KIND_TAB: begin
                        // each space runs its own wrap test
                        in_loop_next = 1'b1;
                        state_next   = ST_WX;
                    end
                    default: begin
                        state_next = ST_DX;
                    end
                endcase
            end
            ST_LFY: begin
                cur_y_next = alu_rsp.sum_sat;
                cur_x_next = '0;
                state_next = ST_IDLE;
            end
            ST_DX: begin
                xend_next  = alu_rsp.sum_sat;
                state_next = ST_DY;
            end
            ST_DY: begin
                yend_next  = alu_rsp.sum_sat;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                // hold until the output register frees up
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    out_x_next    = cur_x_reg;
                    out_y_next    = cur_y_reg;
                    out_xe_next   = xend_reg;
                    out_ye_next   = yend_reg;
                    out_off_next  = off_reg;
                    out_rel_next  = (code_reg != drawn_reg);
                    out_last_next = last_draw;
                    drawn_next    = code_reg;
                    cur_x_next    = xend_reg;
                    if (last_draw) begin
                        state_next = ST_IDLE;
                    end else begin
                        tab_cnt_next = tab_cnt_reg + tcgp_pkg::TAB_CNT_W'(1);
                        state_next   = ST_WX;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            disp_w_reg  <= tcgp_pkg::RST_DISP_W;
            disp_h_reg  <= tcgp_pkg::RST_DISP_H;
            font_w_reg  <= tcgp_pkg::RST_FONT_W;
            font_h_reg  <= tcgp_pkg::RST_FONT_H;
            wide_reg    <= 1'b0;
            first_reg   <= tcgp_pkg::RST_FIRST;
            last_reg    <= tcgp_pkg::RST_LAST;
            state_reg   <= ST_IDLE;
            kind_reg    <= tcgp_pkg::KIND_DRAW;
            in_loop_reg <= 1'b0;
            tab_cnt_reg <= '0;
            cur_x_reg   <= '0;
            cur_y_reg   <= '0;
            drawn_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            disp_w_reg  <= disp_w_next;
            disp_h_reg  <= disp_h_next;
            font_w_reg  <= font_w_next;
            font_h_reg  <= font_h_next;
            wide_reg    <= wide_next;
            first_reg   <= first_next;
            last_reg    <= last_next;
            state_reg   <= state_next;
            kind_reg    <= kind_next;
            in_loop_reg <= in_loop_next;
            tab_cnt_reg <= tab_cnt_next;
            cur_x_reg   <= cur_x_next;
            cur_y_reg   <= cur_y_next;
            drawn_reg   <= drawn_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload and working registers need no reset.
    always_ff @(posedge aclk) begin
        code_reg     <= code_next;
        gw_reg       <= gw_next;
        bpf_reg      <= bpf_next;
        idx_reg      <= idx_next;
        off_reg      <= off_next;
        xend_reg     <= xend_next;
        yend_reg     <= yend_next;
        out_x_reg    <= out_x_next;
        out_y_reg    <= out_y_next;
        out_xe_reg   <= out_xe_next;
        out_ye_reg   <= out_ye_next;
        out_off_reg  <= out_off_next;
        out_rel_reg  <= out_rel_next;
        out_last_reg <= out_last_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_win_x        = out_x_reg;
    assign m_win_y        = out_y_reg;
    assign m_win_x_end    = out_xe_reg;
    assign m_win_y_end    = out_ye_reg;
    assign m_glyph_offset = out_off_reg;
    assign m_reload_glyph = out_rel_reg;
    assign m_last_of_run  = out_last_reg;

    // An accepted word keeps the block busy in the next cycle.
    `TCGP_ASSERT_NXT(a_busy_after_accept, s_valid && s_ready, !s_ready)
    // A result is loaded only into a free output slot.
    `TCGP_ASSERT_IMP(a_load_into_free_slot, load_out, !m_valid_reg || m_ready)
    // After the origin test the cursor row lies inside the display.
    `TCGP_ASSERT_IMP(a_row_in_display, state_reg == ST_ACT,
                     (cur_y_reg < disp_h_reg) || (cur_y_reg == '0))

endmodule

`default_nettype wire

// ===== dv/tb_text_cursor_glyph_placer.sv =====
// Testbench for text_cursor_glyph_placer: directed and random character streams
// checked word by word against a cursor and glyph predictor kept in the bench.
// Depends on tcgp_pkg and the text_cursor_glyph_placer RTL.
module tb_text_cursor_glyph_placer;
    import tcgp_pkg::*;

    localparam int STALL_LIMIT = 3000;
    localparam int SETTLE_CYCLES = 40;
    localparam int unsigned CUR_SAT = 4095;
    localparam int unsigned OFF_SAT = 131071;

    // One expected draw word.
    typedef struct packed {
        logic [CUR_W-1:0] win_x;
        logic [CUR_W-1:0] win_y;
        logic [CUR_W-1:0] win_x_end;
        logic [CUR_W-1:0] win_y_end;
        logic [OFF_W-1:0] glyph_offset;
        logic             reload_glyph;
        logic             last_of_run;
    } glyph_draw_t;

    logic                  aclk;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [CODE_W-1:0]     s_char_code = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [CUR_W-1:0]      m_win_x;
    logic [CUR_W-1:0]      m_win_y;
    logic [CUR_W-1:0]      m_win_x_end;
    logic [CUR_W-1:0]      m_win_y_end;
    logic [OFF_W-1:0]      m_glyph_offset;
    logic                  m_reload_glyph;
    logic                  m_last_of_run;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // Predictor copy of the configuration registers, starting at their reset values.
    int unsigned disp_w  = RST_DISP_W;
    int unsigned disp_h  = RST_DISP_H;
    int unsigned font_w  = RST_FONT_W;
    int unsigned font_h  = RST_FONT_H;
    int unsigned wide_on = 0;
    int unsigned code_lo = RST_FIRST;
    int unsigned code_hi = RST_LAST;

    // Predictor copy of the cursor and the last glyph drawn.
    int unsigned cur_x = 0;
    int unsigned cur_y = 0;
    int unsigned last_code = 0;

    glyph_draw_t pending_draws[$];
    int          mismatch_count = 0;
    int          draw_count = 0;
    int          quiet_cycles = 0;
    bit          calm = 1'b0;
    logic [CODE_W-1:0] prev_pick = 8'd65;

    text_cursor_glyph_placer u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_char_code    (s_char_code),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_win_x        (m_win_x),
        .m_win_y        (m_win_y),
        .m_win_x_end    (m_win_x_end),
        .m_win_y_end    (m_win_y_end),
        .m_glyph_offset (m_glyph_offset),
        .m_reload_glyph (m_reload_glyph),
        .m_last_of_run  (m_last_of_run),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always begin
        aclk = 1'b0;
        #10;
        aclk = 1'b1;
        #10;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic int unsigned sat_cur(input int unsigned v);
        return (v > CUR_SAT) ? CUR_SAT : v;
    endfunction

    // Rendered glyph width: one pixel per subpixel triple, two in wide mode.
    function automatic int unsigned glyph_span();
        int unsigned w;
        w = (font_w + 2) / 3;
        return (wide_on != 0) ? 2 * w : w;
    endfunction

    // Drop to the next row when the glyph would reach the right edge, then home
    // the cursor once it has run off the bottom.
    task automatic wrap_cursor();
        if (cur_x + glyph_span() >= disp_w) begin
            cur_y = sat_cur(cur_y + font_h);
            cur_x = 0;
        end
        if (cur_y >= disp_h) begin
            cur_y = 0;
            cur_x = 0;
        end
    endtask

    task automatic draw_glyph(input int unsigned code, input bit closes_run);
        glyph_draw_t d;
        int unsigned idx;
        int unsigned off;
        int unsigned gw;
        gw  = glyph_span();
        // Codes outside the font, or an empty font range, map to glyph 0.
        idx = (code >= code_lo && code <= code_hi) ? code - code_lo : 0;
        off = idx * ((font_w + 7) / 8) * font_h;
        d.win_x        = CUR_W'(cur_x);
        d.win_y        = CUR_W'(cur_y);
        d.win_x_end    = CUR_W'(sat_cur(cur_x + gw));
        d.win_y_end    = CUR_W'(sat_cur(cur_y + font_h));
        d.glyph_offset = OFF_W'((off > OFF_SAT) ? OFF_SAT : off);
        d.reload_glyph = (code != last_code);
        d.last_of_run  = closes_run;
        pending_draws.push_back(d);
        last_code = code;
        cur_x = sat_cur(cur_x + gw);
    endtask

    // Advance the predicted cursor for one accepted word and queue its draws.
    task automatic place_char(input logic [CODE_W-1:0] code);
        int i;
        wrap_cursor();
        if (code == CODE_CR) begin
            cur_x = 0;
        end else if (code == CODE_LF) begin
            cur_y = sat_cur(cur_y + font_h);
            cur_x = 0;
        end else if (code == CODE_TAB) begin
            // Each expanded space gets its own wrap check.
            for (i = 0; i < TAB_SPACES; i++) begin
                wrap_cursor();
                draw_glyph(CODE_SPACE, i == TAB_SPACES - 1);
            end
        end else begin
            draw_glyph(code, 1'b1);
        end
    endtask

    // ------------------------------------------------------------------
    // Channel drivers
    // ------------------------------------------------------------------

    // Present one character word, with a random idle gap ahead of it unless calm, and hold
    // it until accepted. Leave valid high so a back-to-back word needs no toggle.
    task automatic feed_char(input logic [CODE_W-1:0] code);
        int unsigned gap;
        gap = 0;
        if (!calm) begin
            while ($urandom_range(0, 99) < 9) gap++;
        end
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_char_code <= code;
        do @(posedge aclk); while (!s_ready);
        place_char(code);
    endtask

    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(data);
        do @(posedge aclk); while (!cfg_ready);
    endtask

    // Write all seven registers in turn and mirror them in the predictor.
    task automatic apply_config(input int unsigned dw, input int unsigned dh,
                                input int unsigned fw, input int unsigned fh,
                                input int unsigned wide, input int unsigned lo,
                                input int unsigned hi);
        put_reg(REG_DISP_W, dw);
        put_reg(REG_DISP_H, dh);
        put_reg(REG_FONT_W, fw);
        put_reg(REG_FONT_H, fh);
        put_reg(REG_WIDE, wide);
        put_reg(REG_FIRST, lo);
        put_reg(REG_LAST, hi);
        cfg_valid <= 1'b0;
        disp_w  = dw & 12'hFFF;
        disp_h  = dh & 12'hFFF;
        font_w  = fw & 7'h7F;
        font_h  = fh & 7'h7F;
        wide_on = wide & 1;
        code_lo = lo & 8'hFF;
        code_hi = hi & 8'hFF;
    endtask

    // Drop valid, drain every pending draw, then let a trailing CR or LF finish.
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (pending_draws.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic random_config();
        int unsigned dw, dh, fh, lo, hi;
        dw = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2048) : $urandom_range(1, 160);
        dh = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2048) : $urandom_range(1, 120);
        fh = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 64) : $urandom_range(1, 16);
        lo = $urandom_range(0, 255);
        hi = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 255) : $urandom_range(lo, 255);
        apply_config(dw, dh, $urandom_range(1, 64), fh, $urandom_range(0, 1), lo, hi);
    endtask

    // Codes in the font range half the time, some repeats, control codes and noise.
    function automatic logic [CODE_W-1:0] pick_char();
        int unsigned r;
        logic [CODE_W-1:0] c;
        r = $urandom_range(0, 99);
        if (r < 6)
            c = CODE_CR;
        else if (r < 12)
            c = CODE_LF;
        else if (r < 20)
            c = CODE_TAB;
        else if (r < 30)
            c = prev_pick;
        else if (r < 80 && code_lo <= code_hi)
            c = CODE_W'($urandom_range(code_lo, code_hi));
        else
            c = CODE_W'($urandom_range(0, 255));
        prev_pick = c;
        return c;
    endfunction

    // ------------------------------------------------------------------
    // Result side: random backpressure, checker, watchdog
    // ------------------------------------------------------------------

    always @(posedge aclk) begin
        m_ready <= calm || ($urandom_range(0, 99) >= 9);
    end

    task automatic report_mismatch(input string field, input int unsigned got,
                                   input int unsigned want);
        $display("%0t draw %0d %s: got %0d, expected %0d",
                 $time, draw_count, field, got, want);
        mismatch_count++;
    endtask

    // Compare each accepted draw word with the oldest prediction.
    always @(posedge aclk) begin
        glyph_draw_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_draws.size() == 0) begin
                report_mismatch("no draw pending, win_x", m_win_x, 0);
            end else begin
                want = pending_draws.pop_front();
                if (m_win_x !== want.win_x)
                    report_mismatch("win_x", m_win_x, want.win_x);
                if (m_win_y !== want.win_y)
                    report_mismatch("win_y", m_win_y, want.win_y);
                if (m_win_x_end !== want.win_x_end)
                    report_mismatch("win_x_end", m_win_x_end, want.win_x_end);
                if (m_win_y_end !== want.win_y_end)
                    report_mismatch("win_y_end", m_win_y_end, want.win_y_end);
                if (m_glyph_offset !== want.glyph_offset)
                    report_mismatch("glyph_offset", m_glyph_offset, want.glyph_offset);
                if (m_reload_glyph !== want.reload_glyph)
                    report_mismatch("reload_glyph", m_reload_glyph, want.reload_glyph);
                if (m_last_of_run !== want.last_of_run)
                    report_mismatch("last_of_run", m_last_of_run, want.last_of_run);
            end
            draw_count++;
        end
    end

    // Count cycles with no handshake on any channel; a hang ends the run.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset registers: font bounds, codes on both sides of the font, repeats,
    // byte extremes and controls.
    task automatic test_reset_defaults();
        feed_char(8'd65);
        feed_char(8'd65);
        feed_char(RST_FIRST);
        feed_char(RST_LAST);
        feed_char(RST_LAST + 8'd1);
        feed_char(RST_FIRST - 8'd1);
        feed_char(8'd0);
        feed_char(8'd255);
        feed_char(CODE_CR);
        feed_char(CODE_LF);
        feed_char(CODE_TAB);
        feed_char(8'd66);
    endtask

    // Tiny display: line wrap, wrap inside a tab, LF and a draw
    // that run off the bottom and home the cursor, then a glyph wider than a
    // one-pixel display with first code above last code.
    task automatic test_wrap_and_origin();
        wait_idle();
        apply_config(10, 17, 8, 8, 0, 32, 126);
        feed_char(CODE_TAB);
        feed_char(8'd97);
        feed_char(8'd98);
        feed_char(8'd99);
        feed_char(CODE_LF);
        feed_char(8'd122);
        wait_idle();
        apply_config(1, 1, 64, 64, 1, 200, 100);
        feed_char(8'd81);
        feed_char(8'd250);
        feed_char(CODE_TAB);
    endtask

    // Several register settings, both extremes first, random streams in each.
    task automatic test_random_sweep();
        int phase;
        for (phase = 0; phase < 6; phase++) begin
            wait_idle();
            if (phase == 0)
                apply_config(2048, 2048, 64, 64, 1, 0, 255);
            else if (phase == 1)
                apply_config(1, 1, 1, 1, 0, 255, 0);
            else
                random_config();
            repeat (58) feed_char(pick_char());
        end
    endtask

    // Back-to-back words with the result side always ready.
    task automatic test_calm_stream();
        wait_idle();
        calm = 1'b1;
        random_config();
        repeat (72) feed_char(pick_char());
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        test_reset_defaults();
        test_wrap_and_origin();
        test_random_sweep();
        test_calm_stream();
        wait_idle();
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
